// ===== hdl/klt_pkg.sv =====
// klt_pkg: shared types and constants of the keyword language tokenizer
// token kinds, scan modes, byte codes, keyword spellings and queue sizing
// no dependencies
package klt_pkg;

   localparam int POS_BITS = 16;
   localparam int QDEPTH = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef logic [POS_BITS-1:0] pos_type;
   localparam pos_type POS_MAX = {POS_BITS{1'b1}};

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WORD  = 2'd1,
      MODE_INT   = 2'd2,
      MODE_LABEL = 2'd3
   } scan_mode_type;

   typedef enum logic [3:0] {
      KIND_IDENT   = 4'd0,
      KIND_LABEL   = 4'd1,
      KIND_INT     = 4'd2,
      KIND_INPUT   = 4'd3,
      KIND_OUTPUT  = 4'd4,
      KIND_GOTO    = 4'd5,
      KIND_IF      = 4'd6,
      KIND_THEN    = 4'd7,
      KIND_EQUAL   = 4'd8,
      KIND_PLUS    = 4'd9,
      KIND_LESS    = 4'd10,
      KIND_INVALID = 4'd11,
      KIND_END     = 4'd12
   } lex_kind_type;

   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_LESS = 8'h3C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;

   localparam logic [47:0] WORD_INPUT = 48'h00_696E_7075_74;
   localparam logic [47:0] WORD_OUTPUT = 48'h6F75_7470_7574;
   localparam logic [47:0] WORD_GOTO = 48'h0000_676F_746F;
   localparam logic [47:0] WORD_IF = 48'h0000_0000_6966;
   localparam logic [47:0] WORD_THEN = 48'h0000_7468_656E;

   typedef struct packed {
      lex_kind_type kind;
      logic [15:0]  start;
      logic [15:0]  length;
      logic         last;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    first;
      tok_type    second;
   } push_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } head_type;

endpackage

// ===== hdl/klt_if.sv =====
// klt_req_if and klt_rsp_if: valid/ready channels of the tokenizer
// depends on klt_pkg for the token kind type
interface klt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface klt_rsp_if import klt_pkg::*;;
   logic         valid;
   logic         ready;
   lex_kind_type lex_kind;
   logic [15:0]  value_start;
   logic [15:0]  value_length;
   logic         last_of_run;

   modport source (output valid, output lex_kind, output value_start,
                   output value_length, output last_of_run, input ready);
   modport sink (input valid, input lex_kind, input value_start,
                 input value_length, input last_of_run, output ready);
endinterface

// ===== hdl/klt_scan.sv =====
// klt_scan: front part, classifies each byte and tracks the open token
// pushes up to two tokens per item into the queue; depends on klt_pkg, klt_if
module klt_scan import klt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   klt_req_if.sink       req_chan,
   input  logic          space_ok,
   output push_type      push
);

   scan_mode_type mode_ff, mode_in;
   pos_type       start_ff, start_in;
   pos_type       len_ff, len_in;
   pos_type       position_ff, position_in;
   logic [47:0]   prefix_ff, prefix_in;

   logic           accept;
   logic [7:0]     c;
   logic           eot;
   logic           digit;
   logic           space;
   logic           wordc;
   logic           grow;
   logic           close_valid;
   logic           sec_valid;
   lex_kind_type   kw;
   tok_type        close_tok;
   tok_type        sec_tok;

   assign req_chan.ready = space_ok;

   always_comb begin
      c = req_chan.char_code;
      eot = req_chan.end_of_text;
      accept = req_chan.valid && space_ok;
      digit = (c >= 8'h30) && (c <= 8'h39);
      space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
      wordc = digit || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
              || (c == CHAR_UNDER);
      grow = !eot && (((mode_ff == MODE_INT) && digit)
                      || (((mode_ff == MODE_WORD) || (mode_ff == MODE_LABEL)) && wordc));
      close_valid = !grow && (mode_ff != MODE_IDLE);

      if ((len_ff == pos_type'(5)) && (prefix_ff == WORD_INPUT)) begin
         kw = KIND_INPUT;
      end else if ((len_ff == pos_type'(6)) && (prefix_ff == WORD_OUTPUT)) begin
         kw = KIND_OUTPUT;
      end else if ((len_ff == pos_type'(4)) && (prefix_ff == WORD_GOTO)) begin
         kw = KIND_GOTO;
      end else if ((len_ff == pos_type'(2)) && (prefix_ff == WORD_IF)) begin
         kw = KIND_IF;
      end else if ((len_ff == pos_type'(4)) && (prefix_ff == WORD_THEN)) begin
         kw = KIND_THEN;
      end else begin
         kw = KIND_IDENT;
      end

      close_tok.start = 16'(start_ff);
      close_tok.length = 16'(len_ff);
      case (mode_ff)
         MODE_WORD: begin
            close_tok.kind = kw;
            if (kw != KIND_IDENT) begin
               close_tok.length = '0;
            end
         end
         MODE_INT: close_tok.kind = KIND_INT;
         MODE_LABEL: close_tok.kind = KIND_LABEL;
         default: close_tok.kind = KIND_IDENT;
      endcase

      sec_valid = 1'b0;
      sec_tok.kind = KIND_END;
      sec_tok.start = 16'(position_ff);
      sec_tok.length = '0;
      sec_tok.last = 1'b1;
      if (eot) begin
         sec_valid = 1'b1;
      end else if (!grow) begin
         if (c == CHAR_EQUAL) begin
            sec_valid = 1'b1;
            sec_tok.kind = KIND_EQUAL;
         end else if (c == CHAR_PLUS) begin
            sec_valid = 1'b1;
            sec_tok.kind = KIND_PLUS;
         end else if (c == CHAR_LESS) begin
            sec_valid = 1'b1;
            sec_tok.kind = KIND_LESS;
         end else if (!space && (c != CHAR_COLON) && !wordc) begin
            sec_valid = 1'b1;
            sec_tok.kind = KIND_INVALID;
            sec_tok.length = 16'd1;
         end
      end
      close_tok.last = !sec_valid;

      push.count = accept ? ({1'b0, close_valid} + {1'b0, sec_valid}) : 2'd0;
      push.first = close_valid ? close_tok : sec_tok;
      push.second = sec_tok;

      mode_in = mode_ff;
      start_in = start_ff;
      len_in = len_ff;
      prefix_in = prefix_ff;
      position_in = position_ff;
      if (accept) begin
         position_in = position_ff + pos_type'(1);
         if (eot) begin
            mode_in = MODE_IDLE;
            start_in = '0;
            len_in = '0;
            prefix_in = '0;
            position_in = '0;
         end else if (grow) begin
            if (len_ff < pos_type'(6)) begin
               prefix_in = {prefix_ff[39:0], c};
            end
            if (len_ff != POS_MAX) begin
               len_in = len_ff + pos_type'(1);
            end
         end else if (c == CHAR_COLON) begin
            mode_in = MODE_LABEL;
            start_in = position_ff + pos_type'(1);
            len_in = '0;
            prefix_in = '0;
         end else if (digit) begin
            mode_in = MODE_INT;
            start_in = position_ff;
            len_in = pos_type'(1);
            prefix_in = {40'd0, c};
         end else if (wordc) begin
            mode_in = MODE_WORD;
            start_in = position_ff;
            len_in = pos_type'(1);
            prefix_in = {40'd0, c};
         end else begin
            mode_in = MODE_IDLE;
            len_in = '0;
            prefix_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         start_ff <= '0;
         len_ff <= '0;
         prefix_ff <= '0;
         position_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         start_ff <= start_in;
         len_ff <= len_in;
         prefix_ff <= prefix_in;
         position_ff <= position_in;
      end
   end

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && eot) |=> (mode_ff == MODE_IDLE) && (position_ff == '0) && (len_ff == '0))
      else $error("end of text did not clear scan state");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (len_ff == '0) && (prefix_ff == '0))
      else $error("idle scanner holds token bytes");
   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_WORD) || (mode_ff == MODE_INT)) |-> (len_ff != '0))
      else $error("open word or integer with no bytes");
`endif

endmodule

// ===== hdl/klt_queue.sv =====
// klt_queue: short token queue between scan and emit parts
// takes zero to two tokens per cycle, gives at most one; depends on klt_pkg
module klt_queue import klt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_ok,
   output head_type head,
   input  logic     pop
);

   tok_type                mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   head_ff, head_in;
   logic [QPTR_BITS-1:0]   tail_ff, tail_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QPTR_BITS-1:0]   tail_next;

   assign space_ok = count_ff <= QCNT_BITS'(QDEPTH - 2);
   assign head.valid = count_ff != '0;
   assign head.tok = mem_ff[head_ff];
   assign tail_next = tail_ff + QPTR_BITS'(1);

   always_comb begin
      head_in = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in = tail_ff + QPTR_BITS'(push.count);
      count_in = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_next] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QDEPTH))
      else $error("token queue overflow");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("push without room for two tokens");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty token queue");
`endif

endmodule

// ===== hdl/klt_emit.sv =====
// klt_emit: back part, moves queued tokens into the registered result port
// depends on klt_pkg and klt_if
module klt_emit import klt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   klt_rsp_if.source rsp_chan
);

   logic    valid_ff, valid_in;
   tok_type tok_ff;

   always_comb begin
      pop = head.valid && (!valid_ff || rsp_chan.ready);
      valid_in = pop || (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head.tok;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.lex_kind = tok_ff.kind;
   assign rsp_chan.value_start = tok_ff.start;
   assign rsp_chan.value_length = tok_ff.length;
   assign rsp_chan.last_of_run = tok_ff.last;

endmodule

// ===== hdl/keyword_language_tokenizer_top.sv =====
// keyword_language_tokenizer_top: streaming tokenizer, scan -> queue -> emit
// depends on klt_pkg, klt_if, klt_scan, klt_queue, klt_emit
//
//  channel   dir  payload                                              handshake
//  req_chan  in   char_code[7:0], end_of_text                          valid/ready
//  rsp_chan  out  lex_kind[3:0], value_start, value_length, last_of_run  valid/ready
//
// one byte accepted per cycle while req ready is high; each byte yields zero to two tokens
// a byte's tokens are written into the token queue, then registered into the result port once it is free
// results leave at one per cycle while rsp ready is high, so bytes giving two tokens each are held back
// req ready drops while the four-entry token queue has fewer than two free slots
// synchronous reset clears scan state, queue pointers and the result valid
module keyword_language_tokenizer_top import klt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   klt_req_if.sink   req_chan,
   klt_rsp_if.source rsp_chan
);

   push_type push;
   head_type head;
   logic     space_ok;
   logic     pop;

   klt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .space_ok (space_ok),
      .push     (push)
   );

   klt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .head     (head),
      .pop      (pop)
   );

   klt_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== test/klt_token_checker.sv =====
// klt_token_checker: scans every accepted byte, keeps the tokens it should give
// and compares each token leaving the result channel against the oldest one
// depends on klt_pkg and the klt_req_if / klt_rsp_if interfaces
module klt_token_checker import klt_pkg::*; (
   input  logic clock,
   input  logic reset,
   klt_req_if   req_chan,
   klt_rsp_if   rsp_chan,
   output int   fail_count,
   output int   tokens_pending
);

   scan_mode_type mode;
   pos_type       open_start;
   pos_type       open_length;
   pos_type       next_pos;
   logic [47:0]   prefix;
   tok_type       scanned_tokens[$];
   int            step_tokens;

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic logic is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_word_char(logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
         || c == CHAR_UNDER;
   endfunction

   function automatic lex_kind_type word_kind_of(pos_type len, logic [47:0] p);
      if (len == 5 && p == WORD_INPUT) return KIND_INPUT;
      if (len == 6 && p == WORD_OUTPUT) return KIND_OUTPUT;
      if (len == 4 && p == WORD_GOTO) return KIND_GOTO;
      if (len == 2 && p == WORD_IF) return KIND_IF;
      if (len == 4 && p == WORD_THEN) return KIND_THEN;
      return KIND_IDENT;
   endfunction

   task automatic push_token(lex_kind_type kind, pos_type start, pos_type length);
      tok_type t;
      t.kind = kind;
      t.start = start;
      t.length = length;
      t.last = 1'b0;
      scanned_tokens.push_back(t);
      step_tokens++;
   endtask

   task automatic grow_token(logic [7:0] c);
      if (open_length < 6) prefix = {prefix[39:0], c};
      if (open_length != POS_MAX) open_length++;
   endtask

   task automatic open_token(scan_mode_type m, pos_type start);
      mode = m;
      open_start = start;
      open_length = '0;
      prefix = '0;
   endtask

   task automatic close_token();
      lex_kind_type k;
      case (mode)
         MODE_WORD: begin
            k = word_kind_of(open_length, prefix);
            push_token(k, open_start, k == KIND_IDENT ? open_length : pos_type'(0));
         end
         MODE_INT: push_token(KIND_INT, open_start, open_length);
         MODE_LABEL: push_token(KIND_LABEL, open_start, open_length);
         default: ;
      endcase
      mode = MODE_IDLE;
      open_length = '0;
      prefix = '0;
   endtask

   task automatic clear_scan();
      mode = MODE_IDLE;
      open_start = '0;
      open_length = '0;
      next_pos = '0;
      prefix = '0;
   endtask

   task automatic scan_byte(logic [7:0] c, logic eot);
      tok_type t;
      step_tokens = 0;
      if (eot) begin
         close_token();
         push_token(KIND_END, next_pos, '0);
         clear_scan();
      end else begin
         if (mode == MODE_INT && is_digit(c)) begin
            grow_token(c);
         end else if ((mode == MODE_WORD || mode == MODE_LABEL) && is_word_char(c)) begin
            grow_token(c);
         end else begin
            close_token();
            if (is_space(c)) begin
               // whitespace skipped
            end else if (c == CHAR_EQUAL) begin
               push_token(KIND_EQUAL, next_pos, '0);
            end else if (c == CHAR_PLUS) begin
               push_token(KIND_PLUS, next_pos, '0);
            end else if (c == CHAR_LESS) begin
               push_token(KIND_LESS, next_pos, '0);
            end else if (c == CHAR_COLON) begin
               open_token(MODE_LABEL, pos_type'(next_pos + 1'b1));
            end else if (is_digit(c)) begin
               open_token(MODE_INT, next_pos);
               grow_token(c);
            end else if (is_word_char(c)) begin
               open_token(MODE_WORD, next_pos);
               grow_token(c);
            end else begin
               push_token(KIND_INVALID, next_pos, pos_type'(1));
            end
         end
         next_pos = pos_type'(next_pos + 1'b1);
      end
      if (step_tokens > 0) begin
         t = scanned_tokens.pop_back();
         t.last = 1'b1;
         scanned_tokens.push_back(t);
      end
   endtask

   always @(posedge clock) begin
      tok_type want;
      if (reset) begin
         clear_scan();
         scanned_tokens.delete();
         fail_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            scan_byte(req_chan.char_code, req_chan.end_of_text);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (scanned_tokens.size() == 0) begin
               report_mismatch($sformatf("token kind %0d start %0d with nothing pending",
                  rsp_chan.lex_kind, rsp_chan.value_start));
            end else begin
               want = scanned_tokens.pop_front();
               if (rsp_chan.lex_kind != want.kind)
                  report_mismatch($sformatf("token kind %0d, wanted %0d",
                     rsp_chan.lex_kind, want.kind));
               if (rsp_chan.value_start != want.start)
                  report_mismatch($sformatf("kind %0d start %0d, wanted %0d",
                     want.kind, rsp_chan.value_start, want.start));
               if (rsp_chan.value_length != want.length)
                  report_mismatch($sformatf("kind %0d length %0d, wanted %0d",
                     want.kind, rsp_chan.value_length, want.length));
               if (rsp_chan.last_of_run != want.last)
                  report_mismatch($sformatf("kind %0d last flag %0b, wanted %0b",
                     want.kind, rsp_chan.last_of_run, want.last));
            end
         end
      end
      tokens_pending = scanned_tokens.size();
   end

endmodule

// ===== test/keyword_language_tokenizer_top_tb.sv =====
// keyword_language_tokenizer_top_tb: feeds the tokenizer directed and random text
// with random gaps on both channels and reports the checker's verdict
// depends on klt_pkg, klt_if, keyword_language_tokenizer_top and klt_token_checker
module keyword_language_tokenizer_top_tb;
   import klt_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   tokens_pending;
   int   item_count;
   bit   steady;

   klt_req_if req_chan();
   klt_rsp_if rsp_chan();

   keyword_language_tokenizer_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   klt_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] word_char(bit lead);
      int r;
      r = $urandom_range(lead ? 52 : 62);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      if (r == 52) return CHAR_UNDER;
      return 8'(8'h30 + r - 53);
   endfunction

   function automatic logic [7:0] space_char();
      int r;
      r = $urandom_range(5);
      return r == 5 ? 8'h20 : 8'(8'h09 + r);
   endfunction

   function automatic logic [7:0] invalid_char();
      string punct;
      punct = "!\"#$%&'()*,-./;>?@[\\]^`{|}~";
      case ($urandom_range(3))
         0: return 8'($urandom_range(128, 255));
         1: return 8'($urandom_range(0, 8));
         2: return 8'($urandom_range(14, 31));
         default: return punct[$urandom_range(punct.len() - 1)];
      endcase
   endfunction

   task automatic send_item(logic [7:0] c, logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.char_code <= c;
      req_chan.end_of_text <= eot;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      item_count++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_phrase();
      string keywords[5];
      string s;
      int r;
      int n;
      keywords = '{"input", "output", "goto", "if", "then"};
      r = $urandom_range(99);
      if (r < 18) begin
         s = keywords[$urandom_range(4)];
         case ($urandom_range(9))
            0: s = {s, string'(word_char(1'b0))};
            1: s = s.substr(0, s.len() - 2);
            2: s[0] = s[0] - 8'h20;
            default: ;
         endcase
         send_text(s);
      end else if (r < 33) begin
         n = $urandom_range(0, 8);
         send_item(word_char(1'b1), 1'b0);
         repeat (n) send_item(word_char(1'b0), 1'b0);
      end else if (r < 45) begin
         n = $urandom_range(1, 6);
         repeat (n) send_item(8'(8'h30 + $urandom_range(9)), 1'b0);
      end else if (r < 55) begin
         n = $urandom_range(0, 6);
         send_item(CHAR_COLON, 1'b0);
         repeat (n) send_item(word_char(1'b0), 1'b0);
      end else if (r < 68) begin
         case ($urandom_range(2))
            0: send_item(CHAR_EQUAL, 1'b0);
            1: send_item(CHAR_PLUS, 1'b0);
            default: send_item(CHAR_LESS, 1'b0);
         endcase
      end else if (r < 78) begin
         n = $urandom_range(1, 3);
         repeat (n) send_item(space_char(), 1'b0);
      end else if (r < 88) begin
         send_item(invalid_char(), 1'b0);
      end else begin
         send_item(8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(9) < 6) send_item(space_char(), 1'b0);
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!rsp_chan.ready) begin
            rsp_chan.ready <= 1'b1;
            hold = $urandom_range(0, 10);
         end else begin
            hold = pick_gap();
            if (hold > 0) begin
               rsp_chan.ready <= 1'b0;
               hold--;
            end
         end
      end
   end

   initial begin
      int random_start;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.char_code <= '0;
      req_chan.end_of_text <= 1'b0;
      steady = 1'b0;
      item_count = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every kind, high and zero bytes, empty label, int closed by a letter
      send_text("input=goto<if+then:_7 ");
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_text("output: 12x");
      send_end();

      // words that begin with a keyword but run longer are never keywords, back to back
      steady = 1'b1;
      send_text("outputs inputx thenif ");
      send_item(word_char(1'b1), 1'b0);
      repeat (24) send_item(word_char(1'b0), 1'b0);
      send_text(" 1<");
      send_end();
      steady = 1'b0;

      random_start = item_count;
      while (item_count - random_start < 1000) begin
         if ($urandom_range(49) == 0) steady = !steady;
         send_phrase();
         if ($urandom_range(49) == 0) send_end();
      end
      send_end();
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      while (tokens_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/klt_pkg.sv
hdl/klt_if.sv
hdl/klt_scan.sv
hdl/klt_queue.sv
hdl/klt_emit.sv
hdl/keyword_language_tokenizer_top.sv
test/klt_token_checker.sv
test/keyword_language_tokenizer_top_tb.sv
